// ----- design/bcu_pkg.sv -----
// bcu_pkg: shared widths, defaults and controller/datapath interface types
// for the binomial coefficient unit. No dependencies.
package bcu_pkg;

    localparam int N_W       = 6;
    localparam int COEF_W    = 59;
    localparam int ACC_W     = 64;
    localparam int MAX_N_DEF = 62;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture n and k, start a new word
        logic mul;       // multiply running value by (n - i)
        logic div_step;  // one restoring divide step by (i + 1)
        logic publish;   // copy result into output register
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic more_rounds;  // i below the chosen round count
        logic div_last;     // current divide step is the final one
    } t_dp_sts;

endpackage

// ----- design/bcu_dpath.sv -----
// bcu_dpath: operand registers, 64-bit running value with a 64x6 multiply
// and a bit-serial exact divider, plus the output word register. Uses bcu_pkg.
module bcu_dpath import bcu_pkg::*; #(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic              i_clk,
    input  logic [N_W-1:0]    i_n,
    input  logic [N_W-1:0]    i_k,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic [COEF_W-1:0] o_coefficient,
    output logic              o_k_too_large
);

    localparam logic [N_W-1:0] MAX_N_V = N_W'(MAX_N);

    logic [N_W-1:0]      r_n, r_rounds, r_i, r_rem, r_cnt;
    logic                r_too_large;
    logic [ACC_W-1:0]    r_acc;
    logic [COEF_W-1:0]   r_coef;
    logic                r_flag;

    logic [N_W-1:0]      n_sat, n_diff, mult, divisor;
    logic                too_large;
    logic [ACC_W+N_W-1:0] prod;
    logic [N_W:0]        shifted, trial;
    logic                q_bit;

    // saturate n, flag k above n and form n-k for picking the smaller of k and n-k
    always_comb begin
        n_sat     = (i_n > MAX_N_V) ? MAX_N_V : i_n;
        too_large = (i_k > n_sat);
        n_diff    = n_sat - i_k;
    end

    // multiplier and one restoring divide step
    always_comb begin
        mult    = r_n - r_i;
        divisor = r_i + N_W'(1);
        prod    = r_acc * mult;
        shifted = {r_rem, r_acc[ACC_W-1]};
        trial   = shifted - {1'b0, divisor};
        q_bit   = (shifted >= {1'b0, divisor});
    end

    assign o_sts.more_rounds = (r_i < r_rounds);
    assign o_sts.div_last    = (r_cnt == '0);

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n         <= n_sat;
            r_too_large <= too_large;
            r_rounds    <= too_large ? '0 : ((i_k > n_diff) ? n_diff : i_k);
            r_i         <= '0;
            r_acc       <= ACC_W'(1);
        end else if (i_cmd.mul) begin
            r_acc <= prod[ACC_W-1:0];
            r_rem <= '0;
            r_cnt <= N_W'(ACC_W - 1);
        end else if (i_cmd.div_step) begin
            r_acc <= {r_acc[ACC_W-2:0], q_bit};
            r_rem <= q_bit ? trial[N_W-1:0] : shifted[N_W-1:0];
            r_cnt <= r_cnt - N_W'(1);
            if (r_cnt == '0) begin
                r_i <= r_i + N_W'(1);
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_coef <= r_too_large ? '0 : r_acc[COEF_W-1:0];
            r_flag <= r_too_large;
        end
    end

    assign o_coefficient = r_coef;
    assign o_k_too_large = r_flag;

endmodule

// ----- design/bcu_ctrl.sv -----
// bcu_ctrl: sequencer for load, multiply and divide rounds, and the output
// valid flag. Uses bcu_pkg command and status types.
module bcu_ctrl import bcu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                if (i_sts.more_rounds) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on publish, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // a publish never overwrites a word still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> (!r_out_valid || !i_stall))
        else $error("result published over a waiting word");

    // a publish leaves a valid word
    a_publish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |=> r_out_valid)
        else $error("published word not valid");

    // final divide step returns to the multiply check
    a_div_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_MUL))
        else $error("divide did not end in multiply state");

    // a loaded word enters the round loop
    a_load_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_MUL && !o_cmd.publish))
        else $error("load did not start rounds");

endmodule

// ----- design/binomial_coefficient_unit.sv -----
// binomial_coefficient_unit: top level joining bcu_ctrl and bcu_dpath.
// Depends on bcu_pkg, bcu_ctrl, bcu_dpath.
//
//   channel | valid   | stall   | fields
//   --------+---------+---------+-------------------------------------
//   input   | i_valid | o_stall | i_n[5:0], i_k[5:0]
//   output  | o_valid | i_stall | o_coefficient[58:0], o_k_too_large
//
// the result is valid after m = min(k, n-k) rounds (0 when k exceeds n), each
// a multiply and then the bit-serial divider's 64 steps; the next word can be
// taken once the result is published; the bit-serial divider sets the pace
// one word is in work at a time; o_stall is high from acceptance until the
// result moves to the output register
// the finished result waits in the output register while i_stall is high,
// and the next word may be accepted meanwhile
// i_rst_n is synchronous and clears the sequencer and output valid only
module binomial_coefficient_unit import bcu_pkg::*; #(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [N_W-1:0]    i_n,
    input  logic [N_W-1:0]    i_k,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [COEF_W-1:0] o_coefficient,
    output logic              o_k_too_large
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    bcu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // arithmetic
    bcu_dpath #(
        .MAX_N (MAX_N)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_n           (i_n),
        .i_k           (i_k),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_coefficient (o_coefficient),
        .o_k_too_large (o_k_too_large)
    );

endmodule

// ----- tb/binomial_coefficient_unit_tb.sv -----
// binomial_coefficient_unit_tb: self-checking bench for the binomial coefficient unit,
// with its own multiplicative-rule predictor, random idling on both channels and a stall test.
// Depends on bcu_pkg and binomial_coefficient_unit.
module binomial_coefficient_unit_tb;
    import bcu_pkg::*;

    localparam int SET_MAX         = MAX_N_DEF;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int DRAIN_CYCLES    = 2100;
    localparam int CYCLE_LIMIT     = 3000000;

    typedef struct packed {
        logic [N_W-1:0]    n;
        logic [N_W-1:0]    k;
        logic [COEF_W-1:0] coefficient;
        logic              k_too_large;
    } t_choose_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [N_W-1:0]    i_n;
    logic [N_W-1:0]    i_k;
    logic              o_valid;
    logic              i_stall;
    logic [COEF_W-1:0] o_coefficient;
    logic              o_k_too_large;

    t_choose_word pending_words[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    bit           quiet          = 1'b0;
    bit           hold_off_req   = 1'b0;

    binomial_coefficient_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_n           (i_n),
        .i_k           (i_k),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_coefficient (o_coefficient),
        .o_k_too_large (o_k_too_large)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // expected coefficient by the multiplicative rule, n saturated to the set limit
    function automatic t_choose_word predict_choose(logic [N_W-1:0] n_in,
                                                    logic [N_W-1:0] k_in);
        t_choose_word w;
        logic [ACC_W-1:0] n;
        logic [ACC_W-1:0] k;
        logic [ACC_W-1:0] acc;
        logic [ACC_W-1:0] i;
        w.n = n_in;
        w.k = k_in;
        n = ACC_W'(n_in);
        k = ACC_W'(k_in);
        if (n > ACC_W'(SET_MAX)) n = ACC_W'(SET_MAX);
        if (k > n) begin
            w.coefficient = '0;
            w.k_too_large = 1'b1;
        end else begin
            if (k > n - k) k = n - k;
            acc = ACC_W'(1);
            for (i = '0; i < k; i++) begin
                acc = acc * (n - i);
                acc = acc / (i + ACC_W'(1));
            end
            w.coefficient = acc[COEF_W-1:0];
            w.k_too_large = 1'b0;
        end
        return w;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // operands weighted toward few rounds, with some k above n and some full range
    task automatic pick_operands(output logic [N_W-1:0] n, output logic [N_W-1:0] k);
        int r;
        int n_eff;
        int m;
        r = $urandom_range(0, 99);
        n = N_W'($urandom_range(0, 63));
        n_eff = (n > SET_MAX) ? SET_MAX : int'(n);
        if (r < 45) begin
            m = $urandom_range(0, 4);
            if (m > n_eff) k = N_W'(m);
            else k = $urandom_range(0, 1) ? N_W'(m) : N_W'(n_eff - m);
        end else if (r < 60) begin
            n = N_W'($urandom_range(0, 62));
            k = N_W'($urandom_range(n + 1, 63));
        end else if (r < 85) begin
            k = N_W'($urandom_range(0, 63));
        end else begin
            n = N_W'($urandom_range(0, 20));
            k = N_W'($urandom_range(0, n));
        end
    endtask

    // offer one word and record its expected result once the unit is idle again
    task automatic send_word(input logic [N_W-1:0] n, input logic [N_W-1:0] k);
        int gap;
        gap = quiet ? 0 : pick_pause();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_n     <= n;
        i_k     <= k;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        pending_words.push_back(predict_choose(n, k));
    endtask

    // field extremes, saturation of n, k above n, k at 0 and at n
    task automatic test_edges();
        logic [N_W-1:0] n_list[20];
        logic [N_W-1:0] k_list[20];
        n_list = '{6'd0, 6'd0, 6'd62, 6'd63, 6'd63, 6'd63, 6'd62, 6'd62, 6'd1, 6'd5,
                   6'd10, 6'd10, 6'd61, 6'd63, 6'd0, 6'd62, 6'd63, 6'd45, 6'd42, 6'd21};
        k_list = '{6'd0, 6'd1, 6'd31, 6'd31, 6'd63, 6'd62, 6'd0, 6'd62, 6'd1, 6'd6,
                   6'd3, 6'd7, 6'd30, 6'd0, 6'd63, 6'd61, 6'd32, 6'd45, 6'd21, 6'd42};
        foreach (n_list[j]) send_word(n_list[j], k_list[j]);
    endtask

    // receiver holds off for a long stretch while words keep coming
    task automatic test_back_pressure();
        logic [N_W-1:0] n;
        hold_off_req = 1'b1;
        repeat (12) begin
            n = N_W'($urandom_range(3, 63));
            send_word(n, N_W'($urandom_range(0, 3)));
        end
    endtask

    // stretch with no idling on either side
    task automatic test_back_to_back();
        logic [N_W-1:0] n;
        logic [N_W-1:0] k;
        quiet = 1'b1;
        repeat (20) begin
            n = N_W'($urandom_range(0, 63));
            k = $urandom_range(0, 1) ? N_W'($urandom_range(0, 2))
                                     : N_W'($urandom_range(n, 63));
            send_word(n, k);
        end
        quiet = 1'b0;
    endtask

    task automatic test_random(input int count);
        logic [N_W-1:0] n;
        logic [N_W-1:0] k;
        repeat (count) begin
            pick_operands(n, k);
            send_word(n, k);
        end
    endtask

    // receiver stall: random runs, a long hold-off on request, none while quiet
    initial begin : result_stall_gen
        int  run_len;
        bit  level;
        i_stall = 1'b0;
        run_len = 0;
        level   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                run_len = 0;
            end else begin
                if (run_len == 0) begin
                    if (quiet) begin
                        level   = 1'b0;
                        run_len = 1;
                    end else begin
                        level   = ($urandom_range(0, 2) == 0);
                        run_len = level ? pick_pause() + 1 : $urandom_range(1, 12);
                    end
                end
                i_stall <= level;
                run_len--;
            end
        end
    end

    // compare each delivered word with the oldest expectation
    initial begin : result_check
        t_choose_word want;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                if (pending_words.size() == 0) begin
                    $display("%0t: unexpected word coefficient=%0d k_too_large=%0b",
                             $time, o_coefficient, o_k_too_large);
                    mismatch_count++;
                end else begin
                    want = pending_words.pop_front();
                    if (o_coefficient !== want.coefficient) begin
                        $display("%0t: n=%0d k=%0d coefficient expected %0d actual %0d",
                                 $time, want.n, want.k, want.coefficient, o_coefficient);
                        mismatch_count++;
                    end
                    if (o_k_too_large !== want.k_too_large) begin
                        $display("%0t: n=%0d k=%0d k_too_large expected %0b actual %0b",
                                 $time, want.n, want.k, want.k_too_large, o_k_too_large);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // test sequence
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_n     = '0;
        i_k     = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edges();
        test_back_pressure();
        test_back_to_back();
        test_random(240);

        // drain remaining words
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_words.size() != 0) mismatch_count++;

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/bcu_pkg.sv
design/bcu_dpath.sv
design/bcu_ctrl.sv
design/binomial_coefficient_unit.sv
tb/binomial_coefficient_unit_tb.sv
